>>> sv/barometric_sensor_compensation_core_macros.svh
// Assertion macros shared by the barometric compensation core.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define BSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define BSC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bsc_pkg.sv
// Shared types, constants and helper functions of the barometric compensation core.
package bsc_pkg;

	localparam int DivLen = 32;
	localparam int AddrW  = 5;

	localparam logic [2:0] RegAc1Ac2 = 3'd0;
	localparam logic [2:0] RegAc3Ac4 = 3'd1;
	localparam logic [2:0] RegAc5Ac6 = 3'd2;
	localparam logic [2:0] RegB1B2   = 3'd3;
	localparam logic [2:0] RegMcMd   = 3'd4;
	localparam logic [2:0] RegOss    = 3'd5;

	localparam logic [1:0]  OssReset   = 2'd3;
	localparam logic [31:0] TempOffset = 32'd4000;
	localparam logic [31:0] B4Bias     = 32'd32768;
	localparam logic [31:0] PressScale = 32'd50000;
	localparam logic [31:0] SignBit    = 32'h8000_0000;
	localparam logic [31:0] PolyA      = 32'd3038;
	localparam logic [31:0] PolyB      = 32'hFFFF_E343;
	localparam logic [31:0] PolyC      = 32'd3791;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} coef_t;

	typedef struct packed {
		logic        fault;
		logic        neg;
		logic [18:0] up;
		logic [15:0] temp;
		logic [31:0] a;
	} ctx_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

endpackage

>>> sv/bsc_cfg.sv
// APB register file holding the calibration coefficients and oversampling setting.
module bsc_cfg import bsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output coef_t            coef
);

	logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
	logic [1:0]  oss_q;
	logic        wr;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
			oss_q     <= OssReset;
		end else if (wr) begin
			unique case (paddr[AddrW-1:2])
				RegAc1Ac2: ac1_ac2_q <= pwdata;
				RegAc3Ac4: ac3_ac4_q <= pwdata;
				RegAc5Ac6: ac5_ac6_q <= pwdata;
				RegB1B2:   b1_b2_q   <= pwdata;
				RegMcMd:   mc_md_q   <= pwdata;
				RegOss:    oss_q     <= pwdata[1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[AddrW-1:2])
			RegAc1Ac2: prdata = ac1_ac2_q;
			RegAc3Ac4: prdata = ac3_ac4_q;
			RegAc5Ac6: prdata = ac5_ac6_q;
			RegB1B2:   prdata = b1_b2_q;
			RegMcMd:   prdata = mc_md_q;
			RegOss:    prdata = {30'd0, oss_q};
			default:   prdata = '0;
		endcase
	end

	assign coef = '{ac1: ac1_ac2_q[31:16], ac2: ac1_ac2_q[15:0],
		ac3: ac3_ac4_q[31:16], ac4: ac3_ac4_q[15:0],
		ac5: ac5_ac6_q[31:16], ac6: ac5_ac6_q[15:0],
		b1: b1_b2_q[31:16], b2: b1_b2_q[15:0],
		mc: mc_md_q[31:16], md: mc_md_q[15:0], oss: oss_q};

endmodule

>>> sv/bsc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband context.
module bsc_div import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [31:0] dvd,
	input  logic [31:0] dvs,
	input  ctx_t        in_ctx,
	output logic        out_vld,
	output logic [31:0] quo,
	output ctx_t        out_ctx
);

	logic            vld_s [DivLen+1];
	logic [31:0]     rem_s [DivLen+1];
	logic [31:0]     num_s [DivLen+1];
	logic [31:0]     dvs_s [DivLen+1];
	ctx_t            ctx_s [DivLen+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = '0;
	assign num_s[0] = dvd;
	assign dvs_s[0] = dvs;
	assign ctx_s[0] = in_ctx;

	for (genvar i = 0; i < DivLen; i++) begin : g_stage
		logic [32:0] trial;
		logic        ge;

		assign trial = {rem_s[i], num_s[i][31]};
		assign ge    = trial >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? 32'(trial - {1'b0, dvs_s[i]}) : trial[31:0];
				num_s[i+1] <= {num_s[i][30:0], ge};
				dvs_s[i+1] <= dvs_s[i];
				ctx_s[i+1] <= ctx_s[i];
			end
		end
	end

	assign out_vld = vld_s[DivLen];
	assign quo     = num_s[DivLen];
	assign out_ctx = ctx_s[DivLen];

endmodule

>>> sv/barometric_sensor_compensation_core.sv
// Top level of the barometric sensor temperature and pressure compensation pipeline.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  input     | in_valid / in_ready  | raw_temp[15:0], raw_press[18:0]
//  output    | out_valid / out_ready| temp_tenths, press_pa, div_fault
//  config    | psel/penable/pwrite  | paddr[4:2] register, pwdata, prdata
//
// One request enters per cycle while the pipe is not stalled; the path runs through the two
// 32-stage dividers (temperature, then pressure) plus 15 arithmetic stages around them.
// The whole pipe advances together: it stalls only while the final result
// register is full and not taken, and bubbles move on otherwise.
// Reset clears every valid bit; coefficients return to zero, oversampling to 3.
`include "barometric_sensor_compensation_core_macros.svh"
module barometric_sensor_compensation_core import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        raw_temp,
	input  logic [18:0]        raw_press,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temp_tenths,
	output logic signed [31:0] press_pa,
	output logic               div_fault,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [AddrW-1:0]   paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	coef_t coef;
	logic  en;

	// advance everything unless the result register is held
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign pready   = 1'b1;

	bsc_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .coef
	);

	// ---------------- temperature front end
	logic        v_s1, v_s2;
	logic [31:0] d_s1, m_s2;
	logic [18:0] up_s1, up_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= {16'd0, raw_temp} - {16'd0, coef.ac6};
			up_s1 <= raw_press;
			m_s2  <= d_s1 * {16'd0, coef.ac5};
			up_s2 <= up_s1;
		end
	end

	// X1, the divisor X1 + MD and the magnitudes for the first divider
	logic [31:0] x1_t, den_t, mcs_t, dvd_a, dvs_a, qa;
	ctx_t        ctx_a_in, ctx_a_out;
	logic        va;

	assign x1_t  = asr32(m_s2, 15);
	assign den_t = x1_t + sx16(coef.md);
	assign mcs_t = sx16(coef.mc) << 11;
	assign dvd_a = mcs_t[31] ? 32'(-mcs_t) : mcs_t;
	assign dvs_a = den_t[31] ? 32'(-den_t) : den_t;
	assign ctx_a_in = '{fault: den_t == '0, neg: mcs_t[31] ^ den_t[31], up: up_s2,
		temp: '0, a: x1_t};

	bsc_div u_div_temp (
		.clk, .arst_n, .en, .in_vld(v_s2), .dvd(dvd_a), .dvs(dvs_a), .in_ctx(ctx_a_in),
		.out_vld(va), .quo(qa), .out_ctx(ctx_a_out)
	);

	// ---------------- B5, temperature, and the pressure coefficients
	logic        v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic        f_s4, f_s5, f_s6, f_s7, f_s8, f_s9, f_s10, f_s11, f_s12;
	logic [18:0] up_s4, up_s5, up_s6, up_s7, up_s8, up_s9, up_s10;
	logic [15:0] tp_s5, tp_s6, tp_s7, tp_s8, tp_s9, tp_s10, tp_s11, tp_s12;
	logic [31:0] b5_s4, b6_s5, p1_s6, p2_s6, p3_s6, sq_s7, x2a_s7, x1c_s7;
	logic [31:0] p4_s8, p5_s8, x2a_s8, x1c_s8, b3_s9, x3c_s9, b3_s10, b4m_s10;
	logic [31:0] b4_s11, d2_s11, b4_s12, b7_s12;
	logic [31:0] t5, x3_9;
	logic [15:0] sat5;

	assign t5 = asr32(b5_s4 + 32'd8, 4);

	// clamp to the signed 16-bit range
	always_comb begin
		if ($signed(t5) > 32'sd32767) begin
			sat5 = 16'h7FFF;
		end else if ($signed(t5) < -32'sd32768) begin
			sat5 = 16'h8000;
		end else begin
			sat5 = t5[15:0];
		end
	end

	assign x3_9 = asr32(p4_s8, 11) + x2a_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (en) begin
			v_s4  <= va;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s4   <= ctx_a_out.a + (ctx_a_out.neg ? 32'(-qa) : qa);
			f_s4    <= ctx_a_out.fault;
			up_s4   <= ctx_a_out.up;

			tp_s5   <= sat5;
			b6_s5   <= b5_s4 - TempOffset;
			f_s5    <= f_s4;
			up_s5   <= up_s4;

			p1_s6   <= b6_s5 * b6_s5;
			p2_s6   <= sx16(coef.ac2) * b6_s5;
			p3_s6   <= sx16(coef.ac3) * b6_s5;
			f_s6    <= f_s5;
			up_s6   <= up_s5;
			tp_s6   <= tp_s5;

			sq_s7   <= asr32(p1_s6, 12);
			x2a_s7  <= asr32(p2_s6, 11);
			x1c_s7  <= asr32(p3_s6, 13);
			f_s7    <= f_s6;
			up_s7   <= up_s6;
			tp_s7   <= tp_s6;

			p4_s8   <= sx16(coef.b2) * sq_s7;
			p5_s8   <= sx16(coef.b1) * sq_s7;
			x2a_s8  <= x2a_s7;
			x1c_s8  <= x1c_s7;
			f_s8    <= f_s7;
			up_s8   <= up_s7;
			tp_s8   <= tp_s7;

			b3_s9   <= asr32((((sx16(coef.ac1) << 2) + x3_9) << coef.oss) + 32'd2, 2);
			x3c_s9  <= asr32(x1c_s8 + asr32(p5_s8, 16) + 32'd2, 2);
			f_s9    <= f_s8;
			up_s9   <= up_s8;
			tp_s9   <= tp_s8;

			b4m_s10 <= {16'd0, coef.ac4} * (x3c_s9 + B4Bias);
			b3_s10  <= b3_s9;
			f_s10   <= f_s9;
			up_s10  <= up_s9;
			tp_s10  <= tp_s9;

			b4_s11  <= b4m_s10 >> 15;
			f_s11   <= f_s10 || ((b4m_s10 >> 15) == '0);
			d2_s11  <= {13'd0, up_s10} - b3_s10;
			tp_s11  <= tp_s10;

			b7_s12  <= d2_s11 * (PressScale >> coef.oss);
			b4_s12  <= b4_s11;
			f_s12   <= f_s11;
			tp_s12  <= tp_s11;
		end
	end

	// ---------------- B7 / B4 on the second divider
	logic [31:0] dvd_b, qb;
	ctx_t        ctx_b_in, ctx_b_out;
	logic        vb;

	// below the sign bit, double before dividing; otherwise double the quotient
	assign dvd_b    = (b7_s12 < SignBit) ? (b7_s12 << 1) : b7_s12;
	assign ctx_b_in = '{fault: f_s12, neg: !(b7_s12 < SignBit), up: '0, temp: tp_s12,
		a: '0};

	bsc_div u_div_press (
		.clk, .arst_n, .en, .in_vld(v_s12), .dvd(dvd_b), .dvs(b4_s12), .in_ctx(ctx_b_in),
		.out_vld(vb), .quo(qb), .out_ctx(ctx_b_out)
	);

	// ---------------- final pressure correction
	logic        v_s14, v_s15, v_s16;
	logic        f_s14, f_s15, f_s16;
	logic [15:0] tp_s14, tp_s15, tp_s16;
	logic [31:0] p_s14, p_s15, p_s16, sqp_s15, x2m_s15, x1b_s16, x2_s16;
	logic [31:0] ph15, pf17;

	assign ph15 = asr32(p_s14, 8);
	assign pf17 = p_s16 + asr32(asr32(x1b_s16, 16) + x2_s16 + PolyC, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s14, v_s15, v_s16, out_valid} <= '0;
		end else if (en) begin
			v_s14     <= vb;
			v_s15     <= v_s14;
			v_s16     <= v_s15;
			out_valid <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s14   <= ctx_b_out.neg ? (qb << 1) : qb;
			f_s14   <= ctx_b_out.fault;
			tp_s14  <= ctx_b_out.temp;

			sqp_s15 <= ph15 * ph15;
			x2m_s15 <= p_s14 * PolyB;
			p_s15   <= p_s14;
			f_s15   <= f_s14;
			tp_s15  <= tp_s14;

			x1b_s16 <= sqp_s15 * PolyA;
			x2_s16  <= asr32(x2m_s15, 16);
			p_s16   <= p_s15;
			f_s16   <= f_s15;
			tp_s16  <= tp_s15;

			// drop both results on a zero divisor
			press_pa    <= f_s16 ? 32'sd0 : $signed(pf17);
			temp_tenths <= f_s16 ? 16'sd0 : $signed(tp_s16);
			div_fault   <= f_s16;
		end
	end

	`BSC_ASSERT_IMP(a_fault_zero, out_valid && div_fault, press_pa == 32'sd0 && temp_tenths == 16'sd0, "fault result carries nonzero data")
	`BSC_ASSERT_NXT(a_stall_hold, !en, $stable(v_s4) && $stable(v_s14), "pipeline moved during a stall")

endmodule
